// File: sv/assert_macros.svh
// Assertion macros shared by the vertex transform modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define VT44_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) expr) else $error(msg);

// Check a property on every clock edge, reset included.
`define VT44_ASSERT_RST(label, expr, msg) \
   label: assert property (@(posedge clock) expr) else $error(msg);

`endif

// File: sv/vt44_pkg.sv
// Shared types and constants for the 4x4 vertex transform.
package vt44_pkg;

   localparam int Lanes         = 4;
   localparam int DataWidth     = 32;
   localparam int FracBits      = 16;
   localparam int ProdWidth     = 2 * DataWidth;
   localparam int ShiftWidth    = ProdWidth - FracBits;
   localparam int PairWidth     = ShiftWidth + 1;
   localparam int SumWidth      = ShiftWidth + 2;
   localparam int EntryCount    = Lanes * Lanes;
   localparam int RegCount      = EntryCount / 2;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 2 * DataWidth;

   localparam logic [CsrIndexWidth-1:0] RegCountIdx = CsrIndexWidth'(RegCount);

   // Register reset values: two Q16.16 entries each, identity matrix overall.
   localparam logic [RegCount-1:0][CsrDataWidth-1:0] RegResetValues = '{
      64'h0001_0000_0000_0000,  // cols3_rows23
      64'h0000_0000_0000_0000,  // cols3_rows01
      64'h0000_0000_0001_0000,  // cols2_rows23
      64'h0000_0000_0000_0000,  // cols2_rows01
      64'h0000_0000_0000_0000,  // cols1_rows23
      64'h0001_0000_0000_0000,  // cols1_rows01
      64'h0000_0000_0000_0000,  // cols0_rows23
      64'h0000_0000_0001_0000   // cols0_rows01
   };

   // Per-stage load enables of the elastic pipeline.
   typedef struct packed {
      logic adv1;
      logic adv2;
      logic adv_out;
   } pipe_ctl_type;

endpackage

// File: sv/vt44_matrix.sv
// Matrix register file: eight 64-bit registers, two Q16.16 entries each.
`include "assert_macros.svh"

module vt44_matrix
   import vt44_pkg::*;
(
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   wr_en,
   input  logic [CsrIndexWidth-1:0]               wr_index,
   input  logic [CsrDataWidth-1:0]                wr_data,
   output logic [EntryCount-1:0][DataWidth-1:0]   entry
);

   logic [RegCount-1:0][CsrDataWidth-1:0] reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff <= RegResetValues;
      end else if (wr_en && (wr_index < RegCountIdx)) begin
         reg_ff[wr_index[$clog2(RegCount)-1:0]] <= wr_data;
      end
   end

   always_comb begin
      for (int i = 0; i < RegCount; i++) begin
         entry[2*i]     = reg_ff[i][DataWidth-1:0];
         entry[2*i + 1] = reg_ff[i][CsrDataWidth-1:DataWidth];
      end
   end

   `VT44_ASSERT(a_bad_index_ignored, (wr_en && (wr_index >= RegCountIdx)) |=> $stable(reg_ff), "write beyond the register list changed the matrix")

endmodule

// File: sv/vt44_lane.sv
// One output row: four products, pairwise sums, final sum.
module vt44_lane
   import vt44_pkg::*;
(
   input  logic                                clock,
   input  pipe_ctl_type                        ctl,
   input  logic [Lanes-1:0][DataWidth-1:0]     coef,
   input  logic [Lanes-1:0][DataWidth-1:0]     vec,
   output logic signed [SumWidth-1:0]          sum
);

   logic signed [DataWidth-1:0]  coef_s  [Lanes];
   logic signed [DataWidth-1:0]  vec_s   [Lanes];
   logic signed [ProdWidth-1:0]  prod_in [Lanes];
   logic signed [ProdWidth-1:0]  prod_ff [Lanes];
   logic signed [ShiftWidth-1:0] shifted [Lanes];
   logic signed [PairWidth-1:0]  pair_in [2];
   logic signed [PairWidth-1:0]  pair_ff [2];

   // Full-precision signed products; dropping the low bits floors them.
   always_comb begin
      for (int k = 0; k < Lanes; k++) begin
         coef_s[k]  = $signed(coef[k]);
         vec_s[k]   = $signed(vec[k]);
         prod_in[k] = coef_s[k] * vec_s[k];
         shifted[k] = $signed(prod_ff[k][ProdWidth-1:FracBits]);
      end
      pair_in[0] = PairWidth'(shifted[0]) + PairWidth'(shifted[1]);
      pair_in[1] = PairWidth'(shifted[2]) + PairWidth'(shifted[3]);
   end

   always_ff @(posedge clock) begin
      if (ctl.adv1) begin
         prod_ff <= prod_in;
      end
      if (ctl.adv2) begin
         pair_ff <= pair_in;
      end
   end

   assign sum = SumWidth'(pair_ff[0]) + SumWidth'(pair_ff[1]);

endmodule

// File: sv/vt44_merge.sv
// Merge stage: saturate the four lane sums into the result register.
module vt44_merge
   import vt44_pkg::*;
(
   input  logic                              clock,
   input  pipe_ctl_type                      ctl,
   input  logic signed [SumWidth-1:0]        sum [Lanes],
   output logic signed [DataWidth-1:0]       out_x,
   output logic signed [DataWidth-1:0]       out_y,
   output logic signed [DataWidth-1:0]       out_z,
   output logic signed [DataWidth-1:0]       out_w
);

   localparam logic signed [DataWidth-1:0] SatMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] SatMin = {1'b1, {(DataWidth-1){1'b0}}};

   logic signed [DataWidth-1:0] res_in [Lanes];
   logic signed [DataWidth-1:0] res_ff [Lanes];

   // In range when all bits above the result's sign bit match it.
   always_comb begin
      for (int r = 0; r < Lanes; r++) begin
         if ((&sum[r][SumWidth-1:DataWidth-1]) || !(|sum[r][SumWidth-1:DataWidth-1])) begin
            res_in[r] = sum[r][DataWidth-1:0];
         end else if (sum[r][SumWidth-1]) begin
            res_in[r] = SatMin;
         end else begin
            res_in[r] = SatMax;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv_out) begin
         res_ff <= res_in;
      end
   end

   assign out_x = res_ff[0];
   assign out_y = res_ff[1];
   assign out_z = res_ff[2];
   assign out_w = res_ff[3];

endmodule

// File: sv/vertex_transform_4x4.sv
// Three register stages between the accepting edge and rsp_valid.
// Throughput: one request per cycle while req_stall is low; four lanes, four 32x32 multipliers each.
// Pipeline: products, pairwise sums, then saturation into the result register.
// Bubbles collapse, so a new request is taken while a result waits.
// Reset (synchronous): pipeline empties, matrix returns to identity.
`include "assert_macros.svh"

module vertex_transform_4x4
   import vt44_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic signed [DataWidth-1:0]      req_in_x,
   input  logic signed [DataWidth-1:0]      req_in_y,
   input  logic signed [DataWidth-1:0]      req_in_z,
   input  logic signed [DataWidth-1:0]      req_in_w,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [DataWidth-1:0]      rsp_out_x,
   output logic signed [DataWidth-1:0]      rsp_out_y,
   output logic signed [DataWidth-1:0]      rsp_out_z,
   output logic signed [DataWidth-1:0]      rsp_out_w,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [CsrIndexWidth-1:0]         csr_index,
   input  logic [CsrDataWidth-1:0]          csr_data
);

   pipe_ctl_type                          ctl;
   logic                                  s1_v_ff, s1_v_in;
   logic                                  s2_v_ff, s2_v_in;
   logic                                  out_v_ff, out_v_in;
   logic                                  req_accept;
   logic                                  rsp_taken;
   logic [EntryCount-1:0][DataWidth-1:0]  entry;
   logic [Lanes-1:0][DataWidth-1:0]       vec;
   logic signed [SumWidth-1:0]            lane_sum [Lanes];

   // Registers are always writable; the user must write only while idle, the block itself does not enforce it.
   assign csr_ready = 1'b1;

   vt44_matrix u_matrix (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .entry    (entry)
   );

   // Elastic pipeline: a stage loads when it is empty or its successor loads.
   // The output stage loads when empty or when the consumer takes the result.
   always_comb begin
      ctl.adv_out = !out_v_ff || !rsp_stall;
      ctl.adv2    = !s2_v_ff  || ctl.adv_out;
      ctl.adv1    = !s1_v_ff  || ctl.adv2;
   end

   assign req_stall  = !ctl.adv1;
   assign req_accept = req_valid && !req_stall;
   assign rsp_taken  = rsp_valid && !rsp_stall;

   // Advance valid bits alongside the data they qualify; hold otherwise.
   always_comb begin
      s1_v_in  = ctl.adv1    ? req_valid : s1_v_ff;
      s2_v_in  = ctl.adv2    ? s1_v_ff   : s2_v_ff;
      out_v_in = ctl.adv_out ? s2_v_ff   : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
         out_v_ff <= out_v_in;
      end
   end

   assign rsp_valid = out_v_ff;

   // Vector component k multiplies column k of the matrix.
   assign vec[0] = req_in_x;
   assign vec[1] = req_in_y;
   assign vec[2] = req_in_z;
   assign vec[3] = req_in_w;

   // One lane per output row; row r uses column-major entries k*4+r.
   for (genvar r = 0; r < Lanes; r++) begin : g_lane
      logic [Lanes-1:0][DataWidth-1:0] coef;

      always_comb begin
         for (int k = 0; k < Lanes; k++) begin
            coef[k] = entry[k*Lanes + r];
         end
      end

      vt44_lane u_lane (
         .clock (clock),
         .ctl   (ctl),
         .coef  (coef),
         .vec   (vec),
         .sum   (lane_sum[r])
      );
   end

   vt44_merge u_merge (
      .clock (clock),
      .ctl   (ctl),
      .sum   (lane_sum),
      .out_x (rsp_out_x),
      .out_y (rsp_out_y),
      .out_z (rsp_out_z),
      .out_w (rsp_out_w)
   );

   `VT44_ASSERT_RST(a_reset_empties, reset |=> !rsp_valid, "result valid right after reset")
   `VT44_ASSERT(a_stall_only_full, req_stall |-> (s1_v_ff && s2_v_ff && out_v_ff), "request stalled with a free stage")
   `VT44_ASSERT(a_count_up, (req_accept && !rsp_taken) |=> ($countones({s1_v_ff, s2_v_ff, out_v_ff}) == $past($countones({s1_v_ff, s2_v_ff, out_v_ff})) + 1), "request lost in the pipeline")

endmodule

// File: bench/vertex_transform_4x4_tb.sv
// Self-checking bench for vertex_transform_4x4: directed table, random matrices, random vertices.
`timescale 1ns / 1ps

module vertex_transform_4x4_tb
   import vt44_pkg::*;
();

   localparam int ClockPeriod   = 8;
   localparam int ResetCycles   = 7;
   localparam int PipeLatency   = 3;
   localparam int PhaseCount    = 8;
   localparam int ItemsPerPhase = 160;
   localparam int IdlePercent   = 34;
   localparam int MaxIndex      = (1 << CsrIndexWidth) - 1;

   localparam logic [DataWidth-1:0] One     = 32'h0001_0000;
   localparam logic [DataWidth-1:0] LaneMax = 32'h7FFF_FFFF;
   localparam logic [DataWidth-1:0] LaneMin = 32'h8000_0000;
   localparam logic [DataWidth-1:0] MinusLsb = 32'hFFFF_FFFF;
   localparam int SmallVertex = 1000 * 65536;   // +-1000.0 in Q16.16
   localparam int SmallEntry  = 4 * 65536;      // +-4.0 in Q16.16
   localparam longint SatHigh = 64'sd2147483647;
   localparam longint SatLow  = -64'sd2147483648;

   // one vertex, lane 0 is x, lane 3 is w
   typedef logic [Lanes-1:0][DataWidth-1:0] vec_type;

   typedef enum logic {
      RowWrite,
      RowVector
   } row_kind_type;

   typedef enum int {
      MatAffine,
      MatFull,
      MatSmall,
      MatExtreme,
      MatSparse
   } matrix_style_type;

   typedef struct {
      row_kind_type             kind;
      logic [CsrIndexWidth-1:0] index;
      logic [CsrDataWidth-1:0]  data;
      vec_type                  vin;
      bit                       typed;
      vec_type                  vout;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [DataWidth-1:0]    req_in_x = '0;
   logic signed [DataWidth-1:0]    req_in_y = '0;
   logic signed [DataWidth-1:0]    req_in_z = '0;
   logic signed [DataWidth-1:0]    req_in_w = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [DataWidth-1:0]    rsp_out_x;
   logic signed [DataWidth-1:0]    rsp_out_y;
   logic signed [DataWidth-1:0]    rsp_out_z;
   logic signed [DataWidth-1:0]    rsp_out_w;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [CsrIndexWidth-1:0]       csr_index = '0;
   logic [CsrDataWidth-1:0]        csr_data = '0;

   // shadow copy of the sixteen matrix entries, column-major
   logic [DataWidth-1:0] mat_model [EntryCount];
   vec_type              expected_vertices [$];
   stim_row_type         directed_rows [$];
   string                lane_name [Lanes] = '{"out_x", "out_y", "out_z", "out_w"};

   bit no_idle = 1'b0;
   int errors = 0;
   int requests_sent = 0;
   int directed_sent = 0;
   int results_checked = 0;
   int writes_applied = 0;
   int writes_ignored = 0;
   int saturated_lanes = 0;
   int matrix_setups = 1;

   vertex_transform_4x4 uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_in_x  (req_in_x),
      .req_in_y  (req_in_y),
      .req_in_z  (req_in_z),
      .req_in_w  (req_in_w),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_out_z (rsp_out_z),
      .rsp_out_w (rsp_out_w),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Apply the matrix to one vertex: floor-shift each product, sum exactly, saturate.
   function automatic vec_type transform_vertex(vec_type v);
      vec_type r;
      longint  acc;
      longint  prod;
      for (int row = 0; row < Lanes; row++) begin
         acc = 0;
         for (int k = 0; k < Lanes; k++) begin
            prod = longint'($signed(mat_model[k * Lanes + row])) * longint'($signed(v[k]));
            acc += prod >>> FracBits;   // arithmetic shift rounds toward minus infinity
         end
         if (acc > SatHigh) begin
            acc = SatHigh;
            saturated_lanes++;
         end else if (acc < SatLow) begin
            acc = SatLow;
            saturated_lanes++;
         end
         r[row] = acc[DataWidth-1:0];
      end
      return r;
   endfunction

   function automatic vec_type vec4(logic [DataWidth-1:0] x, logic [DataWidth-1:0] y,
                                    logic [DataWidth-1:0] z, logic [DataWidth-1:0] w);
      return {w, z, y, x};
   endfunction

   function automatic logic [DataWidth-1:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return LaneMax;
         1: return LaneMin;
         2: return '0;
         3: return 32'h0000_0001;
         4: return MinusLsb;
         default: return One;
      endcase
   endfunction

   function automatic logic [DataWidth-1:0] pick_signed(int span);
      return DataWidth'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // Geometric gap: each cycle idles with the chosen odds, none during the busy stretch.
   function automatic int pick_gap();
      int n;
      n = 0;
      while (!no_idle && n < 30 && $urandom_range(0, 99) < IdlePercent) n++;
      return n;
   endfunction

   function automatic vec_type random_vertex();
      vec_type     v;
      int unsigned mode;
      mode = $urandom_range(0, 9);
      for (int l = 0; l < Lanes; l++) begin
         if (mode < 5) v[l] = pick_signed(SmallVertex);
         else if (mode < 8) v[l] = $urandom();
         else v[l] = pick_extreme();
      end
      return v;
   endfunction

   function automatic void add_write(int idx, logic [CsrDataWidth-1:0] data);
      directed_rows.push_back('{RowWrite, CsrIndexWidth'(idx), data, '0, 1'b0, '0});
   endfunction

   function automatic void add_vector(vec_type vin, bit typed, vec_type vout);
      directed_rows.push_back('{RowVector, '0, '0, vin, typed, vout});
   endfunction

   // Hold the request until accepted, then log what must come back.
   task automatic send_request(vec_type v, bit typed, vec_type typed_out);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_x  <= v[0];
      req_in_y  <= v[1];
      req_in_z  <= v[2];
      req_in_w  <= v[3];
      do @(posedge clock); while (req_stall);
      expected_vertices.push_back(typed ? typed_out : transform_vertex(v));
      requests_sent++;
   endtask

   // Drop the request valid, wait until every result is back, let the pipe settle.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (PipeLatency + 2) @(posedge clock);
   endtask

   // Leaves csr_valid high; the caller drops it after the last write of a batch.
   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx < RegCountIdx) begin
         mat_model[2 * idx]     = data[DataWidth-1:0];
         mat_model[2 * idx + 1] = data[CsrDataWidth-1:DataWidth];
         writes_applied++;
      end else begin
         writes_ignored++;
      end
   endtask

   // Build a fresh matrix of the given flavor and load all eight registers in random order.
   task automatic program_matrix(matrix_style_type style);
      logic [DataWidth-1:0] entry [EntryCount];
      int order [RegCount];
      int pick;
      int tmp;
      for (int i = 0; i < EntryCount; i++) begin
         case (style)
            MatAffine:  entry[i] = (i % (Lanes + 1) == 0) ? One : '0;
            MatFull:    entry[i] = $urandom();
            MatSmall:   entry[i] = pick_signed(SmallEntry);
            MatExtreme: entry[i] = pick_extreme();
            default:    entry[i] = $urandom_range(0, 1) ? pick_signed(SmallEntry) : '0;
         endcase
      end
      if (style == MatAffine) begin
         for (int r = 0; r < Lanes - 1; r++) entry[3 * Lanes + r] = pick_signed(100 * 65536);
      end
      // hit the unused indexes first; a_bad_index_ignored flags any change they make to the matrix
      repeat ($urandom_range(1, 2))
         write_reg(CsrIndexWidth'($urandom_range(RegCount, MaxIndex)), {$urandom(), $urandom()});
      for (int i = 0; i < RegCount; i++) order[i] = i;
      for (int i = 0; i < RegCount - 1; i++) begin
         pick = $urandom_range(i, RegCount - 1);
         tmp = order[i];
         order[i] = order[pick];
         order[pick] = tmp;
      end
      for (int i = 0; i < RegCount; i++)
         write_reg(CsrIndexWidth'(order[i]), {entry[2 * order[i] + 1], entry[2 * order[i]]});
      matrix_setups++;
   endtask

   // Receiver: stall at random, except during the busy stretch.
   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < IdlePercent);
   end

   // Compare every accepted result against the oldest outstanding expectation.
   always @(posedge clock) begin
      vec_type got;
      vec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_w, rsp_out_z, rsp_out_y, rsp_out_x};
         if (expected_vertices.size() == 0) begin
            $error("result with no request outstanding: %h %h %h %h",
                   got[0], got[1], got[2], got[3]);
            errors++;
         end else begin
            want = expected_vertices.pop_front();
            for (int l = 0; l < Lanes; l++) begin
               if (got[l] !== want[l]) begin
                  $error("%s: expected %h, got %h", lane_name[l], want[l], got[l]);
                  errors++;
               end
            end
            results_checked++;
         end
      end
   end

   // Hard stop in case the handshake hangs.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      bit in_writes;
      in_writes = 1'b0;
      for (int i = 0; i < EntryCount; i++) mat_model[i] = (i % (Lanes + 1) == 0) ? One : '0;

      // Identity after reset: every vertex passes straight through.
      add_vector(vec4(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000), 1'b1,
                 vec4(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000));
      add_vector(vec4(LaneMax, LaneMin, '0, MinusLsb), 1'b1, vec4(LaneMax, LaneMin, '0, MinusLsb));
      add_vector(vec4(LaneMin, LaneMax, MinusLsb, '0), 1'b1, vec4(LaneMin, LaneMax, MinusLsb, '0));
      add_vector(vec4(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC), 1'b1,
                 vec4(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC));
      add_vector(vec4(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333), 1'b1,
                 vec4(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h3333_3333));
      // Smallest negative scale on x: a negative product floors to -1, a positive one to 0.
      add_write(0, {32'h0, MinusLsb});
      add_vector(vec4(32'h1, 32'h5, 32'h6, 32'h7), 1'b1, vec4(MinusLsb, 32'h5, 32'h6, 32'h7));
      add_vector(vec4(MinusLsb, 32'h5, 32'h6, 32'h7), 1'b1, vec4('0, 32'h5, 32'h6, 32'h7));
      // Every entry at its maximum: saturate both ways.
      for (int r = 0; r < RegCount; r++) add_write(r, {LaneMax, LaneMax});
      add_vector(vec4(LaneMax, LaneMax, LaneMax, LaneMax), 1'b1,
                 vec4(LaneMax, LaneMax, LaneMax, LaneMax));
      add_vector(vec4(LaneMin, LaneMin, LaneMin, LaneMin), 1'b1,
                 vec4(LaneMin, LaneMin, LaneMin, LaneMin));
      add_vector('0, 1'b1, '0);
      // Every entry at its minimum: the signs flip.
      for (int r = 0; r < RegCount; r++) add_write(r, {LaneMin, LaneMin});
      add_vector(vec4(LaneMin, LaneMin, LaneMin, LaneMin), 1'b1,
                 vec4(LaneMax, LaneMax, LaneMax, LaneMax));
      add_vector(vec4(LaneMax, LaneMax, LaneMax, LaneMax), 1'b1,
                 vec4(LaneMin, LaneMin, LaneMin, LaneMin));
      add_vector(vec4(32'h1, MinusLsb, 32'h0000_7FFF, LaneMin), 1'b0, '0);
      // Writes past the last register must leave the matrix alone.
      add_write(MaxIndex, {CsrDataWidth{1'b1}});
      add_write(RegCount, {2{32'h5555_5555}});
      add_vector(vec4(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000), 1'b0, '0);
      // Back to identity with a translation of (1.0, 2.0).
      add_write(0, {32'h0, One});
      add_write(1, '0);
      add_write(2, {One, 32'h0});
      add_write(3, '0);
      add_write(4, '0);
      add_write(5, {32'h0, One});
      add_write(6, {32'h0002_0000, One});
      add_write(7, {One, 32'h0});
      add_vector(vec4(One, One, One, One), 1'b1,
                 vec4(32'h0002_0000, 32'h0003_0000, One, One));
      add_vector(vec4('0, '0, '0, 32'hFFFF_0000), 1'b1,
                 vec4(32'hFFFF_0000, 32'hFFFE_0000, '0, 32'hFFFF_0000));

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; drain before each batch of writes.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == RowWrite) begin
            if (!in_writes) begin
               quiesce();
               in_writes = 1'b1;
            end
            write_reg(directed_rows[i].index, directed_rows[i].data);
         end else begin
            if (in_writes) begin
               csr_valid <= 1'b0;
               in_writes = 1'b0;
            end
            send_request(directed_rows[i].vin, directed_rows[i].typed, directed_rows[i].vout);
            directed_sent++;
         end
      end

      // Random phases: new matrix each time, one phase with both sides running flat out.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         quiesce();
         no_idle = (phase == 3);
         program_matrix(matrix_style_type'(phase % 5));
         csr_valid <= 1'b0;
         for (int i = 0; i < ItemsPerPhase; i++) begin
            // hold the sender once mid-stream until every result is back
            if (phase == 5 && i == ItemsPerPhase / 2) quiesce();
            send_request(random_vertex(), 1'b0, '0);
         end
      end
      no_idle = 1'b0;
      quiesce();

      $display("Checked %0d transformed vertices from %0d requests (%0d directed), %0d matrices.",
               results_checked, requests_sent, directed_sent, matrix_setups);
      $display("Register writes: %0d applied, %0d to unused indexes; %0d lanes saturated.",
               writes_applied, writes_ignored, saturated_lanes);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
